// ===== rtl/bffc_pkg.sv =====
// bffc_pkg: shared types and constants of the buffer fill feedback controller
// used by bffc_front, bffc_back and the top level (not by bffc_fifo); depends on nothing
`default_nettype none

package bffc_pkg;

  localparam int unsigned FRAMES_W   = 16;
  localparam int unsigned FEEDBACK_W = 20;
  localparam int unsigned ZONE_W     = 3;
  localparam int unsigned QUEUE_DEPTH = 2;

  // register map, selected by paddr[2]
  localparam logic REG_BUFFER_FRAMES = 1'b0;
  localparam logic REG_MAX_STEP      = 1'b1;

  localparam logic [FRAMES_W-1:0] BUFFER_FRAMES_RESET = 16'd16384;
  localparam logic [FRAMES_W-1:0] MAX_STEP_RESET      = 16'd200;

  // percent thresholds on the average fill
  localparam logic [6:0] PCT_SCALE     = 7'd100;
  localparam logic [6:0] PCT_VERY_HIGH = 7'd65;
  localparam logic [6:0] PCT_HIGH      = 7'd45;
  localparam logic [6:0] PCT_MODERATE  = 7'd35;
  localparam logic [6:0] PCT_VERY_LOW  = 7'd20;
  localparam logic [6:0] PCT_LOW       = 7'd30;

  localparam logic [FEEDBACK_W-1:0] FB_NOMINAL   = 20'd1000000;
  localparam logic [FEEDBACK_W-1:0] FB_VERY_HIGH = 20'd999000;
  localparam logic [FEEDBACK_W-1:0] FB_HIGH      = 20'd999500;
  localparam logic [FEEDBACK_W-1:0] FB_LOW       = 20'd1001000;
  localparam logic [FEEDBACK_W-1:0] FB_VERY_LOW  = 20'd1002000;

  typedef enum logic [ZONE_W-1:0] {
    ZONE_VERY_HIGH = 3'd0,
    ZONE_HIGH      = 3'd1,
    ZONE_MODERATE  = 3'd2,
    ZONE_GOOD      = 3'd3,
    ZONE_LOW       = 3'd4,
    ZONE_VERY_LOW  = 3'd5
  } zone_e;

  typedef struct packed {
    logic [FRAMES_W-1:0] used;
  } sample_t;

  typedef struct packed {
    logic [FEEDBACK_W-1:0] feedback;
    logic [ZONE_W-1:0]     zone;
  } result_t;

  typedef struct packed {
    logic    push;
    sample_t sample;
  } sample_push_t;

endpackage

`default_nettype wire

// ===== rtl/bffc_fifo.sv =====
// bffc_fifo: small first-in first-out word queue between the block's parts
// stand-alone, no package needed
`default_nettype none

module bffc_fifo #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             wr_i,
  input  wire logic [WIDTH-1:0] wr_data_i,
  output logic                  full_o,
  input  wire logic             rd_i,
  output logic      [WIDTH-1:0] rd_data_o,
  output logic                  empty_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             do_wr, do_rd;

  assign full_o    = (count_q == CW'(DEPTH));
  assign empty_o   = (count_q == '0);
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_d = count_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bffc_front.sv =====
// bffc_front: range and empty-buffer checks on each status sample, used count
// depends on bffc_pkg
`default_nettype none

module bffc_front (
  input  wire logic                          push_i,
  input  wire logic                          full_i,
  input  wire logic signed [16:0]            avail_frames_i,
  input  wire logic signed [17:0]            delay_frames_i,
  input  wire logic [bffc_pkg::FRAMES_W-1:0] buffer_frames_i,
  output bffc_pkg::sample_push_t             q_push_o
);

  logic                          negative;
  logic [bffc_pkg::FRAMES_W-1:0] avail_u;
  logic                          over_avail;
  logic                          over_delay;
  logic                          buf_empty;
  logic                          keep;

  assign negative   = avail_frames_i[16] || delay_frames_i[17];
  assign avail_u    = avail_frames_i[15:0];
  assign over_avail = (avail_u > buffer_frames_i);
  assign over_delay = (delay_frames_i[16:0] > {buffer_frames_i, 1'b0});
  assign buf_empty  = (delay_frames_i[16:0] == '0) || (avail_u == buffer_frames_i);
  assign keep       = !negative && !over_avail && !over_delay && !buf_empty;

  assign q_push_o.push        = push_i && !full_i && keep;
  assign q_push_o.sample.used = buffer_frames_i - avail_u;

endmodule

`default_nettype wire

// ===== rtl/bffc_back.sv =====
// bffc_back: fill window, running sum, zone choice and feedback stepping
// depends on bffc_pkg; holds the window memory
`default_nettype none

module bffc_back #(
  parameter int unsigned WINDOW = 50
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic [bffc_pkg::FRAMES_W-1:0] buffer_frames_i,
  input  wire logic [bffc_pkg::FRAMES_W-1:0] max_step_i,
  input  wire logic                          in_empty_i,
  input  wire bffc_pkg::sample_t             in_sample_i,
  output logic                               in_pop_o,
  input  wire logic                          out_full_i,
  output logic                               out_push_o,
  output bffc_pkg::result_t                  out_result_o
);

  localparam int unsigned SW   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned NW   = $clog2(WINDOW + 1);
  localparam int unsigned SUMW = $clog2(WINDOW * 65535 + 1);
  localparam int unsigned CW   = $clog2(100 * WINDOW * 65535 + 1);
  localparam int unsigned FW   = bffc_pkg::FEEDBACK_W;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SUM  = 5'b00010,
    ST_MUL  = 5'b00100,
    ST_ZONE = 5'b01000,
    ST_STEP = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [bffc_pkg::FRAMES_W-1:0] win_mem [WINDOW];
  logic [bffc_pkg::FRAMES_W-1:0] old_q;
  logic [bffc_pkg::FRAMES_W-1:0] used_q;
  logic [SW-1:0]                 slot_q, slot_d;
  logic                          full_q, full_d;
  logic [SUMW-1:0]               sum_q, sum_d;
  logic [NW-1:0]                 n_q, n_d;
  logic [CW-1:0]                 lhs_q, rhs_q;
  bffc_pkg::zone_e               zone_q, zone_d;
  logic [FW-1:0]                 target_q, target_d;
  logic [FW-1:0]                 fb_q, fb_d;
  logic [FW-1:0]                 fb_gap;
  logic                          start;

  assign start    = (state_q == ST_IDLE) && !in_empty_i && !out_full_i;
  assign in_pop_o = start;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (start) state_d = ST_SUM;
      ST_SUM:  state_d = ST_MUL;
      ST_MUL:  state_d = ST_ZONE;
      ST_ZONE: state_d = ST_STEP;
      ST_STEP: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // window slot, fill flag and running sum
  always_comb begin
    slot_d = slot_q;
    full_d = full_q;
    sum_d  = sum_q - (full_q ? SUMW'(old_q) : '0) + SUMW'(used_q);
    if (slot_q == SW'(WINDOW - 1)) begin
      slot_d = '0;
      full_d = 1'b1;
    end else begin
      slot_d = slot_q + 1'b1;
    end
    n_d = full_d ? NW'(WINDOW) : NW'(slot_d);
  end

  // zone from exact percent comparisons
  always_comb begin
    if (lhs_q > rhs_q * CW'(bffc_pkg::PCT_VERY_HIGH)) begin
      zone_d = bffc_pkg::ZONE_VERY_HIGH;  target_d = bffc_pkg::FB_VERY_HIGH;
    end else if (lhs_q > rhs_q * CW'(bffc_pkg::PCT_HIGH)) begin
      zone_d = bffc_pkg::ZONE_HIGH;       target_d = bffc_pkg::FB_HIGH;
    end else if (lhs_q > rhs_q * CW'(bffc_pkg::PCT_MODERATE)) begin
      zone_d = bffc_pkg::ZONE_MODERATE;   target_d = bffc_pkg::FB_NOMINAL;
    end else if (lhs_q < rhs_q * CW'(bffc_pkg::PCT_VERY_LOW)) begin
      zone_d = bffc_pkg::ZONE_VERY_LOW;   target_d = bffc_pkg::FB_VERY_LOW;
    end else if (lhs_q < rhs_q * CW'(bffc_pkg::PCT_LOW)) begin
      zone_d = bffc_pkg::ZONE_LOW;        target_d = bffc_pkg::FB_LOW;
    end else begin
      zone_d = bffc_pkg::ZONE_GOOD;       target_d = bffc_pkg::FB_NOMINAL;
    end
  end

  // move towards the target by at most max_step
  always_comb begin
    if (target_q > fb_q) begin
      fb_gap = target_q - fb_q;
      fb_d   = (fb_gap > FW'(max_step_i)) ? fb_q + FW'(max_step_i) : target_q;
    end else begin
      fb_gap = fb_q - target_q;
      fb_d   = (fb_gap > FW'(max_step_i)) ? fb_q - FW'(max_step_i) : target_q;
    end
  end

  assign out_push_o            = (state_q == ST_STEP);
  assign out_result_o.feedback = fb_d;
  assign out_result_o.zone     = zone_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      slot_q  <= '0;
      full_q  <= 1'b0;
      sum_q   <= '0;
      fb_q    <= bffc_pkg::FB_NOMINAL;
    end else begin
      state_q <= state_d;
      if (state_q == ST_SUM) begin
        slot_q <= slot_d;
        full_q <= full_d;
        sum_q  <= sum_d;
      end
      if (state_q == ST_STEP) begin
        fb_q <= fb_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      used_q <= in_sample_i.used;
      old_q  <= win_mem[slot_q];
    end
    if (state_q == ST_SUM) begin
      win_mem[slot_q] <= used_q;
      n_q             <= n_d;
    end
    if (state_q == ST_MUL) begin
      lhs_q <= CW'(sum_q) * CW'(bffc_pkg::PCT_SCALE);
      rhs_q <= CW'(n_q) * CW'(buffer_frames_i);
    end
    if (state_q == ST_ZONE) begin
      zone_q   <= zone_d;
      target_q <= target_d;
    end
  end

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("back sequencer state not one-hot");

  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(slot_q) < WINDOW)
    else $error("window slot out of range");

  a_fb_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fb_q >= bffc_pkg::FB_VERY_HIGH && fb_q <= bffc_pkg::FB_VERY_LOW)
    else $error("feedback left its range");

  a_pop_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_pop_o |-> !out_full_i && !in_empty_i)
    else $error("sample taken without room for its result");

  a_sequence: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> ##3 out_push_o)
    else $error("result not pushed four cycles after start");

endmodule

`default_nettype wire

// ===== rtl/buffer_fill_feedback_controller.sv =====
// buffer fill feedback controller top level: config registers, front checks, sample queue,
// back sequencer and result queue; depends on bffc_pkg, bffc_front, bffc_fifo, bffc_back
// an accepted word passes the sample queue, the back sequencer states SUM, MUL, ZONE and STEP
// and the result queue; the back sequencer takes no new sample until it is back in IDLE; dropped samples
// are filtered combinationally at the front and never reach the back part
// reset: asynchronous active low; registers to defaults, feedback to 1000000, queues empty
`default_nettype none

module buffer_fill_feedback_controller #(
  parameter int unsigned WINDOW = 50
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready,
  input  wire logic               push,
  output logic                    full,
  input  wire logic signed [16:0] avail_frames_i,
  input  wire logic signed [17:0] delay_frames_i,
  output logic                    empty,
  input  wire logic               pop,
  output logic      [19:0]        feedback_o,
  output logic      [2:0]         zone_o
);

  logic [bffc_pkg::FRAMES_W-1:0] buffer_frames_q;
  logic [bffc_pkg::FRAMES_W-1:0] max_step_q;
  logic                          cfg_wr;

  bffc_pkg::sample_push_t q_push;
  bffc_pkg::sample_t      q_sample;
  logic                   q_empty;
  logic                   q_pop;
  logic                   in_q_full;
  logic                   out_push;
  logic                   out_full;
  bffc_pkg::result_t      out_result;
  bffc_pkg::result_t      head_result;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buffer_frames_q <= bffc_pkg::BUFFER_FRAMES_RESET;
      max_step_q      <= bffc_pkg::MAX_STEP_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        bffc_pkg::REG_BUFFER_FRAMES: buffer_frames_q <= pwdata[15:0];
        bffc_pkg::REG_MAX_STEP:      max_step_q      <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      bffc_pkg::REG_BUFFER_FRAMES: prdata = {16'd0, buffer_frames_q};
      bffc_pkg::REG_MAX_STEP:      prdata = {16'd0, max_step_q};
      default:                     prdata = '0;
    endcase
  end

  bffc_front u_front (
    .push_i          (push),
    .full_i          (full),
    .avail_frames_i  (avail_frames_i),
    .delay_frames_i  (delay_frames_i),
    .buffer_frames_i (buffer_frames_q),
    .q_push_o        (q_push)
  );

  // input side stalls while the sample queue is full
  assign full = in_q_full;

  bffc_fifo #(
    .WIDTH ($bits(bffc_pkg::sample_t)),
    .DEPTH (bffc_pkg::QUEUE_DEPTH)
  ) u_in_q (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (q_push.push && !in_q_full),
    .wr_data_i (q_push.sample),
    .full_o    (in_q_full),
    .rd_i      (q_pop),
    .rd_data_o (q_sample),
    .empty_o   (q_empty)
  );

  bffc_back #(
    .WINDOW (WINDOW)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .buffer_frames_i (buffer_frames_q),
    .max_step_i      (max_step_q),
    .in_empty_i      (q_empty),
    .in_sample_i     (q_sample),
    .in_pop_o        (q_pop),
    .out_full_i      (out_full),
    .out_push_o      (out_push),
    .out_result_o    (out_result)
  );

  bffc_fifo #(
    .WIDTH ($bits(bffc_pkg::result_t)),
    .DEPTH (bffc_pkg::QUEUE_DEPTH)
  ) u_out_q (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (out_push),
    .wr_data_i (out_result),
    .full_o    (out_full),
    .rd_i      (pop),
    .rd_data_o (head_result),
    .empty_o   (empty)
  );

  assign feedback_o = head_result.feedback;
  assign zone_o     = head_result.zone;

endmodule

`default_nettype wire
